// ===== rtl/nic_csr_interrupt_block_assert.svh =====
// Assertion macros used by the checker file of the NIC CSR block.
`ifndef NIC_CSR_INTERRUPT_BLOCK_ASSERT_SVH
`define NIC_CSR_INTERRUPT_BLOCK_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NCSR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("NIC CSR block: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NCSR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("NIC CSR block: assertion failed");

`endif

// ===== rtl/nic_csr_pkg.sv =====
// Package for the NIC CSR block: codes, bit masks, transaction types.
`timescale 1ns / 1ps
`default_nettype none

package nic_csr_pkg;

    localparam int SA_W = 48;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_EVENT = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // io window offsets
    localparam logic [4:0] OFS_PROM_LAST = 5'd15;
    localparam logic [4:0] OFS_DATA      = 5'd16;
    localparam logic [4:0] OFS_ADDR      = 5'd18;
    localparam logic [4:0] OFS_RESET     = 5'd20;

    // CSR numbers
    localparam logic [6:0] CSR_STATUS  = 7'd0;
    localparam logic [6:0] CSR_IADR_LO = 7'd1;
    localparam logic [6:0] CSR_IADR_HI = 7'd2;
    localparam logic [6:0] CSR_MASK    = 7'd3;
    localparam logic [6:0] CSR_MAC0    = 7'd12;
    localparam logic [6:0] CSR_MAC1    = 7'd13;
    localparam logic [6:0] CSR_MAC2    = 7'd14;

    // CSR0 bits
    localparam logic [15:0] S_INIT      = 16'h0001;
    localparam logic [15:0] S_STRT      = 16'h0002;
    localparam logic [15:0] S_STOP      = 16'h0004;
    localparam logic [15:0] S_TDMD      = 16'h0008;
    localparam logic [15:0] S_INEA      = 16'h0040;
    localparam logic [15:0] S_IDON      = 16'h0100;
    localparam logic [15:0] S_TINT      = 16'h0200;
    localparam logic [15:0] S_RINT      = 16'h0400;
    localparam logic [15:0] S_MERR      = 16'h0800;
    localparam logic [15:0] EVENT_FIELD = 16'h7F00;
    localparam logic [15:0] IRQ_FIELD   = 16'h5F00;
    localparam logic [15:0] CSR0_KEEP   = EVENT_FIELD | S_INEA | S_STOP | S_STRT | S_INIT;

    typedef struct packed {
        cmd_t        cmd;
        logic [4:0]  io_offset;
        logic [15:0] write_data;
        logic [3:0]  event_bits;
    } item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq_line;
        logic        tx_demand;
        logic        init_request;
        logic        running;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/nic_csr_regs.sv =====
// CSR file of the NIC block: register state and the per-transaction update.
`timescale 1ns / 1ps
`default_nettype none

module nic_csr_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         step_en,
    input  wire nic_csr_pkg::item_t           item,
    input  wire logic [nic_csr_pkg::SA_W-1:0] station_address,
    output nic_csr_pkg::result_t              result
);
    import nic_csr_pkg::*;

    logic [6:0]  ptr_reg, ptr_next;
    logic [15:0] status_reg, status_next;
    logic [15:0] iadr_lo_reg, iadr_lo_next;
    logic [15:0] iadr_hi_reg, iadr_hi_next;
    logic [15:0] mask_reg, mask_next;
    logic [15:0] mac0_reg, mac0_next;
    logic [15:0] mac1_reg, mac1_next;
    logic [15:0] mac2_reg, mac2_next;
    logic [15:0] rd_data;
    logic [15:0] csr_rd;
    logic        tdmd_pulse;
    logic        init_pulse;

    function automatic logic [7:0] prom_byte(input logic [SA_W-1:0] sa,
                                             input logic [4:0] off);
        logic [7:0] b;
        b = 8'h00;
        if (off < 5'd6) begin
            b = sa[{off[2:0], 3'b000} +: 8];
        end
        return b;
    endfunction

    function automatic logic [15:0] csr0_write(input logic [15:0] s,
                                               input logic [15:0] v);
        logic [15:0] n;
        n = s & ~(v & EVENT_FIELD);
        n = (n & ~S_INEA) | (v & S_INEA);
        // STOP wins over INIT and STRT in the same write
        if ((v & S_STOP) != 16'h0000) begin
            n = (n | S_STOP) & ~(S_STRT | S_INIT);
        end else begin
            if ((v & S_INIT) != 16'h0000) begin
                n = n | S_INIT;
            end
            if ((v & S_STRT) != 16'h0000) begin
                n = (n | S_STRT) & ~S_STOP;
            end
        end
        return n & CSR0_KEEP;
    endfunction

    always_comb begin
        case (ptr_reg)
            CSR_STATUS:  csr_rd = status_reg;
            CSR_IADR_LO: csr_rd = iadr_lo_reg;
            CSR_IADR_HI: csr_rd = iadr_hi_reg;
            CSR_MASK:    csr_rd = mask_reg;
            CSR_MAC0:    csr_rd = mac0_reg;
            CSR_MAC1:    csr_rd = mac1_reg;
            CSR_MAC2:    csr_rd = mac2_reg;
            default:     csr_rd = 16'h0000;
        endcase
    end

    always_comb begin
        ptr_next     = ptr_reg;
        status_next  = status_reg;
        iadr_lo_next = iadr_lo_reg;
        iadr_hi_next = iadr_hi_reg;
        mask_next    = mask_reg;
        mac0_next    = mac0_reg;
        mac1_next    = mac1_reg;
        mac2_next    = mac2_reg;
        rd_data      = 16'h0000;
        tdmd_pulse   = 1'b0;
        init_pulse   = 1'b0;
        if (step_en) begin
            case (item.cmd)
                CMD_WRITE: begin
                    if (item.io_offset == OFS_ADDR) begin
                        ptr_next = item.write_data[6:0];
                    end else if (item.io_offset == OFS_DATA) begin
                        case (ptr_reg)
                            CSR_STATUS: begin
                                status_next = csr0_write(status_reg, item.write_data);
                                tdmd_pulse  = item.write_data[3];
                                init_pulse  = item.write_data[0] & ~item.write_data[2];
                            end
                            CSR_IADR_LO: iadr_lo_next = item.write_data;
                            CSR_IADR_HI: iadr_hi_next = item.write_data;
                            CSR_MASK:    mask_next    = item.write_data;
                            CSR_MAC0:    mac0_next    = item.write_data;
                            CSR_MAC1:    mac1_next    = item.write_data;
                            CSR_MAC2:    mac2_next    = item.write_data;
                            default: ;
                        endcase
                    end
                end
                CMD_READ: begin
                    if (item.io_offset inside {[5'd0:OFS_PROM_LAST]}) begin
                        rd_data = {prom_byte(station_address, item.io_offset + 5'd1),
                                   prom_byte(station_address, item.io_offset)};
                    end else if (item.io_offset == OFS_DATA) begin
                        rd_data = csr_rd;
                    end else if (item.io_offset == OFS_ADDR) begin
                        rd_data = {9'b0, ptr_reg};
                    end else if (item.io_offset == OFS_RESET) begin
                        // reload defaults, MAC words from the station address
                        ptr_next     = 7'd0;
                        status_next  = S_STOP;
                        iadr_lo_next = 16'h0000;
                        iadr_hi_next = 16'h0000;
                        mask_next    = 16'h0000;
                        mac0_next    = station_address[15:0];
                        mac1_next    = station_address[31:16];
                        mac2_next    = station_address[47:32];
                    end
                end
                CMD_EVENT: begin
                    status_next = status_reg | {4'b0000, item.event_bits, 8'h00};
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        result.read_data    = rd_data;
        result.irq_line     = ((status_next & ~mask_next & IRQ_FIELD) != 16'h0000);
        result.tx_demand    = tdmd_pulse;
        result.init_request = init_pulse;
        result.running      = status_next[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= 7'd0;
            status_reg  <= S_STOP;
            iadr_lo_reg <= 16'h0000;
            iadr_hi_reg <= 16'h0000;
            mask_reg    <= 16'h0000;
            mac0_reg    <= 16'h0000;
            mac1_reg    <= 16'h0000;
            mac2_reg    <= 16'h0000;
        end else begin
            ptr_reg     <= ptr_next;
            status_reg  <= status_next;
            iadr_lo_reg <= iadr_lo_next;
            iadr_hi_reg <= iadr_hi_next;
            mask_reg    <= mask_next;
            mac0_reg    <= mac0_next;
            mac1_reg    <= mac1_next;
            mac2_reg    <= mac2_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nic_csr_interrupt_block.sv =====
// Top level of the NIC CSR block: stream handshake, input and result registers.
//
//  channel   | valid/ready                  | payload
//  ----------+------------------------------+-------------------------------------
//  s_axis    | s_axis_tvalid/s_axis_tready  | tuser cmd, tdata offset/data/events
//  m_axis    | m_axis_tvalid/m_axis_tready  | tdata read_data, irq, tdmd, init, run
//  cfg       | cfg_we (no ready)            | cfg_wdata station address
//
// One transaction per cycle sustained while the result side is not stalled.
// The input register feeds the CSR update logic, which loads the result register.
// A stalled result holds; the input register still takes one more transaction.
// aresetn is synchronous, active low, resets the CSRs (CSR0 to STOP) and clears the station address.
`timescale 1ns / 1ps
`default_nettype none

module nic_csr_interrupt_block (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [nic_csr_pkg::SA_W-1:0] cfg_wdata,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // [4:0] io_offset, [20:5] write_data, [24:21] event_bits, [31:25] zero
    input  wire logic [31:0]                  s_axis_tdata,
    // [1:0] cmd
    input  wire logic [1:0]                   s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [15:0] read_data, [16] irq_line, [17] tx_demand, [18] init_request,
    // [19] running, [23:20] zero
    output logic [23:0]                       m_axis_tdata
);
    import nic_csr_pkg::*;

    logic [SA_W-1:0] sa_reg, sa_next;
    item_t           in_item_reg;
    logic            in_vld_reg, in_vld_next;
    result_t         out_res_reg;
    logic            out_vld_reg, out_vld_next;
    result_t         step_res;
    logic            in_accept;
    logic            advance;

    assign advance       = in_vld_reg & (~out_vld_reg | m_axis_tready);
    assign s_axis_tready = ~in_vld_reg | advance;
    assign in_accept     = s_axis_tvalid & s_axis_tready;

    assign sa_next      = cfg_we ? cfg_wdata : sa_reg;
    assign in_vld_next  = in_accept | (in_vld_reg & ~advance);
    assign out_vld_next = advance | (out_vld_reg & ~m_axis_tready);

    nic_csr_regs u_regs (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_en         (advance),
        .item            (in_item_reg),
        .station_address (sa_reg),
        .result          (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sa_reg      <= '0;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            sa_reg      <= sa_next;
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_item_reg.cmd        <= cmd_t'(s_axis_tuser);
            in_item_reg.io_offset  <= s_axis_tdata[4:0];
            in_item_reg.write_data <= s_axis_tdata[20:5];
            in_item_reg.event_bits <= s_axis_tdata[24:21];
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'b0000, out_res_reg.running, out_res_reg.init_request,
                            out_res_reg.tx_demand, out_res_reg.irq_line,
                            out_res_reg.read_data};

endmodule

`default_nettype wire

// ===== rtl/nic_csr_chk.sv =====
// Port-level checker for the NIC CSR block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "nic_csr_interrupt_block_assert.svh"

module nic_csr_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);

    // padding above the result fields stays zero
    `NCSR_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_axis_tvalid, m_axis_tdata[23:20] == 4'h0)

    // a command pulse comes from a CSR0 write, which returns no read data
    `NCSR_ASSERT_IMP(a_pulse_no_rdata, aclk, aresetn, m_axis_tvalid && (m_axis_tdata[17] || m_axis_tdata[18]), m_axis_tdata[15:0] == 16'h0000)

    // a result appearing on an idle output went through the input and result registers without waiting
    `NCSR_ASSERT_IMP(a_latency, aclk, aresetn, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

    // hold a stalled result
    `NCSR_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind nic_csr_interrupt_block nic_csr_chk u_nic_csr_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== bench/nic_csr_interrupt_block_tb.sv =====
// Self-checking testbench for the NIC CSR block: register access, events and interrupt line.
`timescale 1ns / 1ps

module nic_csr_interrupt_block_tb;
    import nic_csr_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int MAX_REPORTS = 40;
    localparam logic [6:0] CSR_NUMS [7] = '{CSR_STATUS, CSR_IADR_LO, CSR_IADR_HI, CSR_MASK,
                                            CSR_MAC0, CSR_MAC1, CSR_MAC2};

    typedef struct {
        bit      fixed;
        result_t want;
    } preset_t;

    typedef struct {
        item_t   it;
        preset_t p;
    } dir_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [SA_W-1:0]    cfg_wdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata = '0;
    logic [1:0]         s_axis_tuser = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [23:0]        m_axis_tdata;

    // shadow copy of the block's registers
    logic [SA_W-1:0]    station = '0;
    logic [6:0]         csr_ptr;
    logic [15:0]        csr0;
    logic [15:0]        iadr [2];
    logic [15:0]        imask;
    logic [15:0]        mac [3];

    preset_t            preset_q [$];
    result_t            pending_results [$];
    dir_row_t           dir_rows [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asks = 0;
    int mismatches = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_stations = 0;
    int idle_cycles = 0;

    nic_csr_interrupt_block dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void restore_csr_defaults();
        csr_ptr = '0;
        csr0 = S_STOP;
        iadr[0] = '0;
        iadr[1] = '0;
        imask = '0;
        mac[0] = station[15:0];
        mac[1] = station[31:16];
        mac[2] = station[47:32];
    endfunction

    function automatic logic [7:0] prom_byte(int off);
        return (off < 6) ? station[8*off +: 8] : 8'h00;
    endfunction

    // Apply one bus access or event to the shadow registers; return the result it yields.
    function automatic result_t csr_bus_step(item_t it);
        result_t    r;
        logic [15:0] v;
        logic [15:0] s;
        r = '0;
        v = it.write_data;
        case (it.cmd)
            CMD_WRITE: begin
                if (it.io_offset == OFS_ADDR) begin
                    csr_ptr = v[6:0];
                end else if (it.io_offset == OFS_DATA) begin
                    case (csr_ptr)
                        CSR_STATUS: begin
                            s = csr0 & ~(v & EVENT_FIELD);
                            s = (s & ~S_INEA) | (v & S_INEA);
                            if ((v & S_STOP) != 0) begin
                                // stop overrides init and start in the same write
                                s = (s | S_STOP) & ~(S_STRT | S_INIT);
                            end else begin
                                if ((v & S_INIT) != 0) begin
                                    s = s | S_INIT;
                                    r.init_request = 1'b1;
                                end
                                if ((v & S_STRT) != 0) begin
                                    s = (s | S_STRT) & ~S_STOP;
                                end
                            end
                            r.tx_demand = ((v & S_TDMD) != 0);
                            csr0 = s & CSR0_KEEP;
                        end
                        CSR_IADR_LO: iadr[0] = v;
                        CSR_IADR_HI: iadr[1] = v;
                        CSR_MASK:    imask = v;
                        CSR_MAC0:    mac[0] = v;
                        CSR_MAC1:    mac[1] = v;
                        CSR_MAC2:    mac[2] = v;
                        default: ;
                    endcase
                end
            end
            CMD_READ: begin
                if (it.io_offset <= OFS_PROM_LAST) begin
                    r.read_data = {prom_byte(int'(it.io_offset) + 1),
                                   prom_byte(int'(it.io_offset))};
                end else if (it.io_offset == OFS_DATA) begin
                    case (csr_ptr)
                        CSR_STATUS:  r.read_data = csr0;
                        CSR_IADR_LO: r.read_data = iadr[0];
                        CSR_IADR_HI: r.read_data = iadr[1];
                        CSR_MASK:    r.read_data = imask;
                        CSR_MAC0:    r.read_data = mac[0];
                        CSR_MAC1:    r.read_data = mac[1];
                        CSR_MAC2:    r.read_data = mac[2];
                        default:     r.read_data = '0;
                    endcase
                end else if (it.io_offset == OFS_ADDR) begin
                    r.read_data = {9'd0, csr_ptr};
                end else if (it.io_offset == OFS_RESET) begin
                    restore_csr_defaults();
                end
            end
            CMD_EVENT: csr0 = csr0 | {4'd0, it.event_bits, 8'd0};
            default: ;
        endcase
        r.irq_line = ((csr0 & ~imask & IRQ_FIELD) != 0);
        r.running = ((csr0 & S_STRT) != 0);
        return r;
    endfunction

    function automatic item_t random_access();
        item_t it;
        int    k;
        it.cmd = cmd_t'($urandom_range(0, 3));
        it.io_offset = 5'($urandom);
        it.write_data = 16'($urandom);
        it.event_bits = 4'($urandom);
        k = $urandom_range(0, 99);
        if (k < 22) begin
            it.cmd = CMD_WRITE;
            it.io_offset = OFS_ADDR;
            if ($urandom_range(0, 4) != 0)
                it.write_data[6:0] = CSR_NUMS[$urandom_range(0, 6)];
        end else if (k < 44) begin
            it.cmd = CMD_WRITE;
            it.io_offset = OFS_DATA;
            // keep stop out of most writes so the running state lasts
            if ($urandom_range(0, 2) != 0)
                it.write_data = it.write_data & ~S_STOP;
        end else if (k < 62) begin
            it.cmd = CMD_READ;
            it.io_offset = OFS_DATA;
        end else if (k < 74) begin
            it.cmd = CMD_EVENT;
        end else if (k < 82) begin
            it.cmd = CMD_READ;
            it.io_offset = 5'($urandom_range(0, 15));
        end else if (k < 85) begin
            it.cmd = CMD_READ;
            it.io_offset = OFS_RESET;
        end else if (k < 88) begin
            it.cmd = CMD_READ;
            it.io_offset = OFS_ADDR;
        end
        return it;
    endfunction

    task automatic flag_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %h, want %h", name, got, want));
    endtask

    task automatic row_fixed(cmd_t c, logic [4:0] off, logic [15:0] d, logic [3:0] ev,
                             logic [15:0] rd, logic irq, logic tdmd, logic ireq, logic run);
        dir_row_t row;
        row.it = '{cmd: c, io_offset: off, write_data: d, event_bits: ev};
        row.p.fixed = 1'b1;
        row.p.want = '{read_data: rd, irq_line: irq, tx_demand: tdmd,
                       init_request: ireq, running: run};
        dir_rows.push_back(row);
    endtask

    task automatic row_pred(cmd_t c, logic [4:0] off, logic [15:0] d, logic [3:0] ev);
        dir_row_t row;
        row.it = '{cmd: c, io_offset: off, write_data: d, event_bits: ev};
        row.p.fixed = 1'b0;
        row.p.want = '0;
        dir_rows.push_back(row);
    endtask

    task automatic send_access(item_t it, preset_t p);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        preset_q.push_back(p);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, it.event_bits, it.write_data, it.io_offset};
        s_axis_tuser <= it.cmd;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Drop valid and wait until every transaction has its result and the block is idle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (preset_q.size() != 0 || pending_results.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic load_station(logic [SA_W-1:0] sa);
        cfg_we <= 1'b1;
        cfg_wdata <= sa;
        @(posedge aclk);
        cfg_we <= 1'b0;
        station = sa;
        n_stations++;
    endtask

    task automatic run_phase(int n, int send_pct, int stall_pct, bit squeeze);
        preset_t p;
        int      i;
        p.fixed = 1'b0;
        p.want = '0;
        recv_stall_pct = stall_pct;
        send_idle_pct = squeeze ? 0 : send_pct;
        if (squeeze)
            hold_asks++;
        for (i = 0; i < n; i++) begin
            if (squeeze && i == 40)
                send_idle_pct = send_pct;
            send_access(random_access(), p);
        end
        settle();
    endtask

    // result side: random stall, with a long hold-off whenever one is asked for
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : monitor
        item_t   acc;
        result_t got;
        result_t want;
        preset_t p;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                acc.cmd = cmd_t'(s_axis_tuser);
                acc.io_offset = s_axis_tdata[4:0];
                acc.write_data = s_axis_tdata[20:5];
                acc.event_bits = s_axis_tdata[24:21];
                want = csr_bus_step(acc);
                if (preset_q.size() != 0) begin
                    p = preset_q.pop_front();
                    if (p.fixed)
                        want = p.want;
                end
                pending_results.push_back(want);
                n_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.read_data = m_axis_tdata[15:0];
                got.irq_line = m_axis_tdata[16];
                got.tx_demand = m_axis_tdata[17];
                got.init_request = m_axis_tdata[18];
                got.running = m_axis_tdata[19];
                if (pending_results.size() == 0) begin
                    flag_mismatch("result with no transaction waiting");
                end else begin
                    want = pending_results.pop_front();
                    check_field("read_data", got.read_data, want.read_data);
                    check_field("irq_line", 16'(got.irq_line), 16'(want.irq_line));
                    check_field("tx_demand", 16'(got.tx_demand), 16'(want.tx_demand));
                    check_field("init_request", 16'(got.init_request),
                                16'(want.init_request));
                    check_field("running", 16'(got.running), 16'(want.running));
                    n_checked++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("nic_csr_interrupt_block_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int i;
        restore_csr_defaults();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        load_station(48'hFFFF_FFFF_FFFF);

        row_fixed(CMD_READ,  OFS_DATA,      16'h0000, 4'h0, 16'h0004, 0, 0, 0, 0);
        row_fixed(CMD_READ,  OFS_ADDR,      16'hFFFF, 4'hF, 16'h0000, 0, 0, 0, 0);
        row_fixed(CMD_READ,  5'd0,          16'h0000, 4'h0, 16'hFFFF, 0, 0, 0, 0);
        row_fixed(CMD_READ,  5'd5,          16'h0000, 4'h0, 16'h00FF, 0, 0, 0, 0);
        row_fixed(CMD_READ,  OFS_PROM_LAST, 16'h0000, 4'h0, 16'h0000, 0, 0, 0, 0);
        row_fixed(CMD_READ,  5'd31,         16'hFFFF, 4'hF, 16'h0000, 0, 0, 0, 0);
        // upper address bits are ignored
        row_fixed(CMD_WRITE, OFS_ADDR, {9'h1FF, CSR_MAC0}, 4'h0, 16'h0000, 0, 0, 0, 0);
        // MAC words only load from the PROM on a reset-port read
        row_fixed(CMD_READ,  OFS_DATA,      16'h0000, 4'h0, 16'h0000, 0, 0, 0, 0);
        row_fixed(CMD_READ,  OFS_RESET,     16'h0000, 4'h0, 16'h0000, 0, 0, 0, 0);
        row_pred(CMD_WRITE,  OFS_ADDR, {9'd0, CSR_MAC1}, 4'h0);
        row_fixed(CMD_READ,  OFS_DATA,      16'h0000, 4'h0, 16'hFFFF, 0, 0, 0, 0);
        row_pred(CMD_WRITE,  OFS_ADDR, {9'd0, CSR_STATUS}, 4'h0);
        row_fixed(CMD_WRITE, OFS_DATA, S_INEA | S_STRT | S_INIT, 4'h0, 16'h0000, 0, 0, 1, 1);
        row_fixed(CMD_EVENT, 5'd0,          16'h0000, 4'hF, 16'h0000, 1, 0, 0, 1);
        row_fixed(CMD_READ,  OFS_DATA,      16'h0000, 4'h0, 16'h0F43, 1, 0, 0, 1);
        // stop wins over start and init; events clear; demand pulses
        row_fixed(CMD_WRITE, OFS_DATA,      16'hFF0F, 4'h0, 16'h0000, 0, 1, 0, 0);
        row_fixed(CMD_READ,  OFS_DATA,      16'h0000, 4'h0, 16'h0004, 0, 0, 0, 0);
        row_pred(CMD_WRITE,  OFS_ADDR, {9'd0, CSR_MASK}, 4'h0);
        row_pred(CMD_WRITE,  OFS_DATA,      16'hFFFF, 4'h0);
        row_pred(CMD_WRITE,  OFS_ADDR, {9'd0, CSR_STATUS}, 4'h0);
        row_pred(CMD_EVENT,  5'd0,          16'h0000, 4'h5);
        row_pred(CMD_WRITE,  5'd2,          16'hA5A5, 4'h0);
        row_pred(CMD_WRITE,  OFS_RESET,     16'hFFFF, 4'hF);
        row_pred(CMD_NOP,    OFS_DATA,      16'hFFFF, 4'hF);
        row_pred(CMD_WRITE,  OFS_ADDR,      16'h007F, 4'h0);
        row_pred(CMD_WRITE,  OFS_DATA,      16'h1234, 4'h0);
        row_fixed(CMD_READ,  OFS_DATA,      16'h0000, 4'h0, 16'h0000, 0, 0, 0, 0);

        for (i = 0; i < dir_rows.size(); i++)
            send_access(dir_rows[i].it, dir_rows[i].p);
        settle();

        load_station({16'($urandom), 32'($urandom)});
        run_phase(400, 0, 0, 1'b0);
        load_station(48'h0000_0000_0000);
        run_phase(400, 80, 0, 1'b0);
        load_station(48'h8000_0000_0001);
        run_phase(400, 0, 80, 1'b1);
        load_station({16'($urandom), 32'($urandom)});
        run_phase(400, 19, 19, 1'b0);

        $display("covered %0d transactions (directed and random) over %0d station addresses,",
                 n_accepted, n_stations);
        $display("with idle sender, stalled receiver and a long hold-off; %0d results checked",
                 n_checked);
        if (mismatches == 0) begin
            $display("nic_csr_interrupt_block_tb: PASS");
        end else begin
            $display("nic_csr_interrupt_block_tb: FAIL");
        end
        $finish;
    end

endmodule
